>>> hw/rtl/tbpf_pkg.sv
// shared types, constants and helpers of the tiled background pixel fetch
`default_nettype none

package tbpf_pkg;

  localparam int unsigned POS_W       = 16;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned DIM_W       = 14;
  localparam int unsigned ABS_W       = 18;
  localparam int unsigned MOD_STEPS   = 9;
  localparam int unsigned MOD_LAT     = MOD_STEPS + 1;
  localparam int unsigned MPOS_W      = 24;
  localparam int unsigned TPOS_W      = 35;
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned OUT_DEPTH   = 4;

  localparam logic [2:0] REG_KIND     = 3'd0;
  localparam logic [2:0] REG_SCROLL_X = 3'd1;
  localparam logic [2:0] REG_SCROLL_Y = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TILED = 2'd1,
    KIND_LARGE = 2'd2,
    KIND_INF   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_MAP_WR  = 2'd1,
    OP_TILE_WR = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [15:0] idx;
    logic [31:0] val;
    logic [2:0]  px;
    logic [2:0]  py;
    logic        fault;
    logic        zero;
  } entry_t;

  // one restoring remainder step
  function automatic logic [DIM_W-1:0] mod_step(logic [DIM_W-1:0] r, logic b,
                                                logic [DIM_W-1:0] m);
    logic [DIM_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[DIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tbpf_fifo.sv
// small register fifo used for the classified queue and the result buffer
`default_nettype none

module tbpf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           data_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

>>> hw/rtl/tbpf_posmod.sv
// pipelined positive modulo of a signed sum by a 14-bit divisor, two bits a stage
`default_nettype none

module tbpf_posmod (
  input  wire logic                           clk_i,
  input  wire logic signed [tbpf_pkg::SUM_W-1:0] v_i,
  input  wire logic [tbpf_pkg::DIM_W-1:0]     m_i,
  output logic      [tbpf_pkg::DIM_W-1:0]     r_o
);

  localparam int unsigned DW = tbpf_pkg::DIM_W;
  localparam int unsigned AW = tbpf_pkg::ABS_W;
  localparam int unsigned NS = tbpf_pkg::MOD_STEPS;

  logic [DW-1:0]            rem_q [NS];
  logic [AW-1:0]            abs_q [NS];
  logic                     neg_q [NS];
  logic [tbpf_pkg::SUM_W-1:0] mag;
  logic [DW-1:0]            r_q;

  assign mag = v_i[tbpf_pkg::SUM_W-1] ? tbpf_pkg::SUM_W'(-v_i) : tbpf_pkg::SUM_W'(v_i);

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DW-1:0] r_in, r_mid, r_out;
    logic [AW-1:0] a_in;
    logic          n_in;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign a_in = {1'b0, mag};
      assign n_in = v_i[tbpf_pkg::SUM_W-1];
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign a_in = abs_q[k-1];
      assign n_in = neg_q[k-1];
    end
    assign r_mid = tbpf_pkg::mod_step(r_in, a_in[AW-1], m_i);
    assign r_out = tbpf_pkg::mod_step(r_mid, a_in[AW-2], m_i);
    always_ff @(posedge clk_i) begin
      rem_q[k] <= r_out;
      abs_q[k] <= {a_in[AW-3:0], 2'b00};
      neg_q[k] <= n_in;
    end
  end

  // negative sums fold back into 0..m-1
  always_ff @(posedge clk_i) begin
    if (neg_q[NS-1] && (rem_q[NS-1] != '0)) begin
      r_q <= m_i - rem_q[NS-1];
    end else begin
      r_q <= rem_q[NS-1];
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

>>> hw/rtl/tbpf_front.sv
// front: accepts items, scrolls and wraps positions, computes the map index
`default_nettype none

module tbpf_front #(
  parameter int unsigned MAP_DEPTH        = 16384,
  parameter int unsigned TILE_STORE_DEPTH = 65536
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              mode_i,
  input  wire logic signed [15:0]      pos_x_i,
  input  wire logic signed [15:0]      pos_y_i,
  input  wire logic [15:0]             store_index_i,
  input  wire logic [31:0]             store_value_i,
  input  wire tbpf_pkg::cfg_t          cfg_i,
  input  wire logic                    q_pop_i,
  output logic                         push_o,
  output tbpf_pkg::entry_t             push_data_o
);

  localparam int unsigned OCC_W = $clog2(tbpf_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned LAT   = tbpf_pkg::MOD_LAT;
  localparam int unsigned SW    = tbpf_pkg::SUM_W;
  localparam int unsigned DW    = tbpf_pkg::DIM_W;
  localparam int unsigned MW    = tbpf_pkg::MPOS_W;

  logic [OCC_W-1:0] occ_q, occ_d;
  logic             acc;
  tbpf_pkg::op_e    op_in;

  logic                 s0_v_q;
  tbpf_pkg::op_e        s0_op_q;
  logic signed [SW-1:0] s0_sx_q, s0_sy_q;
  logic [15:0]          s0_idx_q;
  logic [31:0]          s0_val_q;

  logic [DW-1:0] mx, my;

  logic          dv_q   [LAT];
  tbpf_pkg::op_e dop_q  [LAT];
  logic [DW-1:0] dsx_q  [LAT];
  logic [15:0]   didx_q [LAT];
  logic [31:0]   dval_q [LAT];

  logic          a_v_q;
  tbpf_pkg::op_e a_op_q;
  logic [DW-1:0] a_x_q, a_y_q, x_sel;
  logic [21:0]   a_prod_q;
  logic [15:0]   a_idx_q;
  logic [31:0]   a_val_q;

  logic [MW-1:0] mpos, xl, yl, x8, y8;
  logic          lx, ly, zero, dim_bad;

  // credit: items accepted and not yet taken from the queue
  assign in_ready_o = (occ_q < OCC_W'(tbpf_pkg::QUEUE_DEPTH));
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    occ_d = occ_q;
    if (acc && !q_pop_i) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (q_pop_i && !acc) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_comb begin
    unique case (tbpf_pkg::op_e'(mode_i))
      tbpf_pkg::OP_READ:    op_in = tbpf_pkg::OP_READ;
      tbpf_pkg::OP_MAP_WR:  op_in = (32'(store_index_i) < 32'(MAP_DEPTH)) ?
                                    tbpf_pkg::OP_MAP_WR : tbpf_pkg::OP_NOP;
      tbpf_pkg::OP_TILE_WR: op_in = (32'(store_index_i) < 32'(TILE_STORE_DEPTH)) ?
                                    tbpf_pkg::OP_TILE_WR : tbpf_pkg::OP_NOP;
      default:              op_in = tbpf_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      s0_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else begin
      occ_q  <= occ_d;
      s0_v_q <= acc;
      dv_q[0] <= s0_v_q;
      for (int k = 1; k < LAT; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      a_v_q <= dv_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s0_op_q  <= op_in;
    s0_sx_q  <= {pos_x_i[15], pos_x_i} + {cfg_i.scroll_x[15], cfg_i.scroll_x};
    s0_sy_q  <= {pos_y_i[15], pos_y_i} + {cfg_i.scroll_y[15], cfg_i.scroll_y};
    s0_idx_q <= store_index_i;
    s0_val_q <= store_value_i;
    dop_q[0]  <= s0_op_q;
    dsx_q[0]  <= s0_sx_q[DW-1:0];
    didx_q[0] <= s0_idx_q;
    dval_q[0] <= s0_val_q;
    for (int k = 1; k < LAT; k++) begin
      dop_q[k]  <= dop_q[k-1];
      dsx_q[k]  <= dsx_q[k-1];
      didx_q[k] <= didx_q[k-1];
      dval_q[k] <= dval_q[k-1];
    end
  end

  tbpf_posmod u_mod_x (
    .clk_i (clk_i),
    .v_i   (s0_sx_q),
    .m_i   (cfg_i.width),
    .r_o   (mx)
  );

  tbpf_posmod u_mod_y (
    .clk_i (clk_i),
    .v_i   (s0_sy_q),
    .m_i   (cfg_i.height),
    .r_o   (my)
  );

  // tiled mode masks x instead of wrapping it
  assign x_sel = (cfg_i.kind == tbpf_pkg::KIND_TILED) ?
                 (dsx_q[LAT-1] & (cfg_i.width - DW'(1))) : mx;

  always_ff @(posedge clk_i) begin
    a_op_q   <= dop_q[LAT-1];
    a_x_q    <= x_sel;
    a_y_q    <= my;
    a_prod_q <= 22'(my[DW-1:3]) * 22'(cfg_i.width[DW-1:3]);
    a_idx_q  <= didx_q[LAT-1];
    a_val_q  <= dval_q[LAT-1];
  end

  assign xl = MW'(a_x_q[7:3]);
  assign yl = MW'(a_y_q[7:3]);
  assign x8 = MW'(a_x_q[DW-1:3]);
  assign y8 = MW'(a_y_q[DW-1:3]);
  assign lx = (a_x_q < DW'(256));
  assign ly = (a_y_q < DW'(256));

  always_comb begin
    if (cfg_i.kind == tbpf_pkg::KIND_TILED) begin
      if (lx && ly) begin
        mpos = xl + (yl << 5);
      end else if (ly) begin
        mpos = MW'(1024) + xl + (yl << 5);
      end else if (lx) begin
        mpos = MW'(2048) + xl + ((y8 - MW'(32)) << 5);
      end else begin
        mpos = MW'(3072) + (x8 - MW'(32)) + ((y8 - MW'(32)) << 5);
      end
    end else begin
      mpos = x8 + MW'(a_prod_q);
    end
  end

  assign zero    = (cfg_i.kind == tbpf_pkg::KIND_NONE);
  assign dim_bad = (cfg_i.width == '0) || (cfg_i.height == '0);

  always_comb begin
    push_data_o.op    = a_op_q;
    push_data_o.idx   = (a_op_q == tbpf_pkg::OP_READ) ? mpos[15:0] : a_idx_q;
    push_data_o.val   = a_val_q;
    push_data_o.px    = a_x_q[2:0];
    push_data_o.py    = a_y_q[2:0];
    push_data_o.zero  = zero;
    push_data_o.fault = !zero && (dim_bad || (mpos >= MW'(MAP_DEPTH)));
  end

  assign push_o = a_v_q;

endmodule

`default_nettype wire

>>> hw/rtl/tbpf_back.sv
// back: map and tile memories, flip handling, result buffer
`default_nettype none

module tbpf_back #(
  parameter int unsigned MAP_DEPTH        = 16384,
  parameter int unsigned TILE_STORE_DEPTH = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire tbpf_pkg::entry_t  q_data_i,
  output logic                   q_pop_o,
  input  wire tbpf_pkg::kind_e   kind_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             pixel_o,
  output logic                   address_fault_o
);

  localparam int unsigned MAP_AW  = $clog2(MAP_DEPTH);
  localparam int unsigned TILE_AW = $clog2(TILE_STORE_DEPTH);
  localparam int unsigned TIW     = (TILE_AW > 16) ? TILE_AW : 16;
  localparam int unsigned TW      = tbpf_pkg::TPOS_W;
  localparam int unsigned OCW     = $clog2(tbpf_pkg::OUT_DEPTH + 1);

  logic [31:0] map_mem  [MAP_DEPTH];
  logic [7:0]  tile_mem [TILE_STORE_DEPTH];

  logic          pop;
  logic [OCW:0]  busy;
  logic [OCW-1:0] ob_cnt;
  logic          ob_empty, ob_pop;
  logic [8:0]    ob_din, ob_dout;

  logic          s1_v_q;
  tbpf_pkg::op_e s1_op_q;
  logic [15:0]   s1_idx_q;
  logic [7:0]    s1_val_q;
  logic [2:0]    s1_px_q, s1_py_q;
  logic          s1_fault_q, s1_zero_q;
  logic [31:0]   map_rd_q;

  logic [28:0]   tile;
  logic          hf, vf, tfault, rd_ok;
  logic [2:0]    pxf, pyf;
  logic [TW-1:0] tpos;
  logic [TIW-1:0] widx;

  logic          s2_v_q, s2_fault_q, s2_zero_q;
  logic [7:0]    tile_rd_q;

  // items in the memory stages plus buffered results must fit the buffer
  assign busy    = (OCW+1)'(s1_v_q) + (OCW+1)'(s2_v_q) + (OCW+1)'(ob_cnt);
  assign pop     = !q_empty_i && (busy < (OCW+1)'(tbpf_pkg::OUT_DEPTH));
  assign q_pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (pop && (q_data_i.op == tbpf_pkg::OP_MAP_WR)) begin
      map_mem[q_data_i.idx[MAP_AW-1:0]] <= q_data_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (q_data_i.op == tbpf_pkg::OP_READ) && !q_data_i.fault && !q_data_i.zero) begin
      map_rd_q <= map_mem[q_data_i.idx[MAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q    <= q_data_i.op;
    s1_idx_q   <= q_data_i.idx;
    s1_val_q   <= q_data_i.val[7:0];
    s1_px_q    <= q_data_i.px;
    s1_py_q    <= q_data_i.py;
    s1_fault_q <= q_data_i.fault;
    s1_zero_q  <= q_data_i.zero;
  end

  always_comb begin
    if (kind_i == tbpf_pkg::KIND_INF) begin
      tile = map_rd_q[28:0];
      hf   = map_rd_q[29];
      vf   = map_rd_q[30];
    end else begin
      tile = 29'(map_rd_q[9:0]);
      hf   = map_rd_q[10];
      vf   = map_rd_q[11];
    end
  end

  assign pxf    = hf ? ~s1_px_q : s1_px_q;
  assign pyf    = vf ? ~s1_py_q : s1_py_q;
  assign tpos   = {tile, pyf, pxf};
  assign tfault = (tpos >= TW'(TILE_STORE_DEPTH));
  assign rd_ok  = s1_v_q && (s1_op_q == tbpf_pkg::OP_READ) && !s1_fault_q && !s1_zero_q
                  && !tfault;
  assign widx   = TIW'(s1_idx_q);

  always_ff @(posedge clk_i) begin
    if (s1_v_q && (s1_op_q == tbpf_pkg::OP_TILE_WR)) begin
      tile_mem[widx[TILE_AW-1:0]] <= s1_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_ok) begin
      tile_rd_q <= tile_mem[tpos[TILE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_zero_q  <= s1_zero_q;
    s2_fault_q <= s1_fault_q || (!s1_zero_q && tfault);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= pop;
      s2_v_q <= s1_v_q && (s1_op_q == tbpf_pkg::OP_READ);
    end
  end

  assign ob_din = {s2_fault_q, (s2_fault_q || s2_zero_q) ? 8'd0 : tile_rd_q};
  assign ob_pop = !ob_empty && out_ready_i;

  tbpf_fifo #(
    .WIDTH (9),
    .DEPTH (tbpf_pkg::OUT_DEPTH)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .data_i  (ob_din),
    .pop_i   (ob_pop),
    .data_o  (ob_dout),
    .empty_o (ob_empty),
    .count_o (ob_cnt)
  );

  assign out_valid_o     = !ob_empty;
  assign pixel_o         = ob_dout[7:0];
  assign address_fault_o = ob_dout[8];

endmodule

`default_nettype wire

>>> hw/rtl/tiled_background_pixel_fetch.sv
// top level: register port, front, classified queue and back
//
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid_i/in_ready_o  | mode_i pos_x_i pos_y_i store_index_i store_value_i
// result   | out_valid_o/out_ready_i| pixel_o address_fault_o
// config   | psel penable pwrite    | paddr pwdata prdata (pready tied high)
//
// one item per cycle sustained while queue credit remains and results are taken; a read
// item's position passes through the 10-stage modulo pipeline in the front.
// writes are applied to the map and tile memories in item order, in the back.
// reset clears control state only; memories hold nothing defined until written.
// the front takes items while queue credit remains (32 items), the back drains
// the queue while its 4-entry result buffer has room, so either side stalls alone.
`default_nettype none

module tiled_background_pixel_fetch #(
  parameter int unsigned MAP_DEPTH        = 16384,
  parameter int unsigned TILE_STORE_DEPTH = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [15:0]        store_index_i,
  input  wire logic [31:0]        store_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              pixel_o,
  output logic                    address_fault_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned EW = $bits(tbpf_pkg::entry_t);

  tbpf_pkg::cfg_t   cfg_q;
  logic             wr_en;
  logic [2:0]       reg_idx;

  logic             push, q_pop, q_empty;
  tbpf_pkg::entry_t push_data, q_data;
  logic [EW-1:0]    q_raw;
  logic [$clog2(tbpf_pkg::QUEUE_DEPTH+1)-1:0] q_cnt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind     <= tbpf_pkg::KIND_NONE;
      cfg_q.scroll_x <= '0;
      cfg_q.scroll_y <= '0;
      cfg_q.width    <= 14'd256;
      cfg_q.height   <= 14'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbpf_pkg::REG_KIND:     cfg_q.kind     <= tbpf_pkg::kind_e'(pwdata[1:0]);
        tbpf_pkg::REG_SCROLL_X: cfg_q.scroll_x <= pwdata[15:0];
        tbpf_pkg::REG_SCROLL_Y: cfg_q.scroll_y <= pwdata[15:0];
        tbpf_pkg::REG_WIDTH:    cfg_q.width    <= pwdata[13:0];
        tbpf_pkg::REG_HEIGHT:   cfg_q.height   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbpf_pkg::REG_KIND:     prdata = 32'(cfg_q.kind);
      tbpf_pkg::REG_SCROLL_X: prdata = {16'd0, cfg_q.scroll_x};
      tbpf_pkg::REG_SCROLL_Y: prdata = {16'd0, cfg_q.scroll_y};
      tbpf_pkg::REG_WIDTH:    prdata = 32'(cfg_q.width);
      tbpf_pkg::REG_HEIGHT:   prdata = 32'(cfg_q.height);
      default:                prdata = '0;
    endcase
  end

  tbpf_front #(
    .MAP_DEPTH        (MAP_DEPTH),
    .TILE_STORE_DEPTH (TILE_STORE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .store_index_i (store_index_i),
    .store_value_i (store_value_i),
    .cfg_i         (cfg_q),
    .q_pop_i       (q_pop),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  tbpf_fifo #(
    .WIDTH (EW),
    .DEPTH (tbpf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (q_pop),
    .data_o  (q_raw),
    .empty_o (q_empty),
    .count_o (q_cnt)
  );

  assign q_data = tbpf_pkg::entry_t'(q_raw);

  tbpf_back #(
    .MAP_DEPTH        (MAP_DEPTH),
    .TILE_STORE_DEPTH (TILE_STORE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty || (q_cnt == '0)),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .kind_i          (cfg_q.kind),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_o         (pixel_o),
    .address_fault_o (address_fault_o)
  );

endmodule

`default_nettype wire

>>> sim/tiled_background_pixel_fetch_tb.sv
// testbench for the tiled background pixel fetch: random and directed items against a predictor
`timescale 1ns / 100ps

module tiled_background_pixel_fetch_tb;

  localparam int MAP_ENTRIES = 16384;
  localparam int TILE_BYTES  = 65536;
  localparam int SETTLE      = 40;

  typedef struct {
    tbpf_pkg::op_e op;
    logic [15:0]   pos_x;
    logic [15:0]   pos_y;
    logic [15:0]   idx;
    logic [31:0]   val;
  } item_t;

  typedef struct {
    logic [7:0] pix;
    logic       flt;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] mode = 2'd0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [15:0] store_index = '0;
  logic [31:0] store_value = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_ready, out_valid, address_fault, pready;
  wire [7:0] pixel;
  wire [31:0] prdata;

  tiled_background_pixel_fetch u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .pos_x_i(pos_x), .pos_y_i(pos_y),
    .store_index_i(store_index), .store_value_i(store_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_o(pixel), .address_fault_o(address_fault),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // active background setup, changed only while the block is idle
  tbpf_pkg::kind_e    cur_kind = tbpf_pkg::KIND_NONE;
  logic signed [15:0] cur_sx = '0;
  logic signed [15:0] cur_sy = '0;
  logic [13:0]        cur_w = 14'd256;
  logic [13:0]        cur_h = 14'd256;

  item_t  pending_items[$];
  pixel_t expected_pixels[$];
  logic [31:0] gen_map[int];
  bit          gen_tile[int];
  logic [31:0] map_mem[int];
  logic [7:0]  tile_mem[int];
  int errors = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;

  function automatic bit quiet_window();
    return no_idle;
  endfunction

  function automatic int wrap_mod(int v, int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // map entry position and in-tile coordinates of a requested point
  function automatic void locate(input logic signed [15:0] rx, input logic signed [15:0] ry,
                                 output longint mpos, output int fx, output int fy);
    int sx, sy, x, y;
    sx = int'(rx) + int'(cur_sx);
    sy = int'(ry) + int'(cur_sy);
    y = wrap_mod(sy, int'(cur_h));
    if (cur_kind == tbpf_pkg::KIND_TILED) begin
      x = sx & (int'(cur_w) - 1);
      if (x < 256 && y < 256) mpos = (x >> 3) + (y >> 3) * 32;
      else if (y < 256) mpos = 1024 + ((x & 255) >> 3) + (y >> 3) * 32;
      else if (x < 256) mpos = 2048 + (x >> 3) + ((y - 256) >> 3) * 32;
      else mpos = 3072 + ((x - 256) >> 3) + ((y - 256) >> 3) * 32;
    end else begin
      x = wrap_mod(sx, int'(cur_w));
      mpos = longint'(x >> 3) + longint'(y >> 3) * longint'(cur_w >> 3);
    end
    fx = x & 7;
    fy = y & 7;
  endfunction

  function automatic longint tile_pos(logic [31:0] e, int fx, int fy);
    longint tile;
    bit hf, vf;
    if (cur_kind == tbpf_pkg::KIND_INF) begin
      tile = e[28:0];
      hf = e[29];
      vf = e[30];
    end else begin
      tile = e[9:0];
      hf = e[10];
      vf = e[11];
    end
    if (hf) fx = 7 - fx;
    if (vf) fy = 7 - fy;
    return tile * 64 + fx + fy * 8;
  endfunction

  function automatic bit fetch_enabled();
    return cur_kind != tbpf_pkg::KIND_NONE && cur_w != 0 && cur_h != 0;
  endfunction

  function automatic pixel_t fetch_pixel(item_t it);
    pixel_t r;
    longint mpos, tpos;
    int fx, fy;
    r.pix = 8'd0;
    r.flt = 1'b0;
    if (cur_kind == tbpf_pkg::KIND_NONE) return r;
    r.flt = 1'b1;
    if (cur_w == 0 || cur_h == 0) return r;
    locate(it.pos_x, it.pos_y, mpos, fx, fy);
    if (mpos >= MAP_ENTRIES) return r;
    tpos = tile_pos(map_mem[int'(mpos)], fx, fy);
    if (tpos >= TILE_BYTES) return r;
    r.pix = tile_mem[int'(tpos)];
    r.flt = 1'b0;
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    bit busy;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        busy = 1'b0;
        it.op = tbpf_pkg::op_e'(mode);
        it.pos_x = pos_x;
        it.pos_y = pos_y;
        it.idx = store_index;
        it.val = store_value;
        case (it.op)
          tbpf_pkg::OP_READ: expected_pixels.push_back(fetch_pixel(it));
          tbpf_pkg::OP_MAP_WR: if (it.idx < MAP_ENTRIES) map_mem[int'(it.idx)] = it.val;
          tbpf_pkg::OP_TILE_WR: tile_mem[int'(it.idx)] = it.val[7:0];
          default: ;
        endcase
      end
      if (!busy) begin
        if (pending_items.size() > 0 && (quiet_window() || $urandom_range(99) >= 12)) begin
          it = pending_items.pop_front();
          mode <= it.op;
          pos_x <= it.pos_x;
          pos_y <= it.pos_y;
          store_index <= it.idx;
          store_value <= it.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once results are flowing
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen == 50) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || $urandom_range(99) >= 12;
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pixel=%0d fault=%0b", pixel, address_fault);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel !== want.pix || address_fault !== want.flt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected pixel=%0d fault=%0b, got pixel=%0d fault=%0b",
                     want.pix, want.flt, pixel, address_fault);
        end
      end
    end
  end

  task automatic push_item(tbpf_pkg::op_e op, logic [15:0] px, logic [15:0] py,
                           logic [15:0] idx, logic [31:0] val);
    item_t it;
    it.op = op;
    it.pos_x = px;
    it.pos_y = py;
    it.idx = idx;
    it.val = val;
    pending_items.push_back(it);
    if (op == tbpf_pkg::OP_MAP_WR && idx < MAP_ENTRIES) gen_map[int'(idx)] = val;
    if (op == tbpf_pkg::OP_TILE_WR) gen_tile[int'(idx)] = 1'b1;
  endtask

  function automatic logic [31:0] random_entry();
    logic [31:0] v;
    v = $urandom;
    if (cur_kind == tbpf_pkg::KIND_INF && $urandom_range(7) != 0)
      v[28:0] = $urandom_range(1023);
    return v;
  endfunction

  // a read, preceded by whatever writes it needs so that no unwritten entry is fetched
  task automatic push_read(logic [15:0] px, logic [15:0] py);
    longint mpos, tpos;
    int fx, fy;
    if (fetch_enabled()) begin
      locate(px, py, mpos, fx, fy);
      if (mpos < MAP_ENTRIES) begin
        if (!gen_map.exists(int'(mpos)))
          push_item(tbpf_pkg::OP_MAP_WR, $urandom, $urandom, mpos[15:0], random_entry());
        tpos = tile_pos(gen_map[int'(mpos)], fx, fy);
        if (tpos < TILE_BYTES && !gen_tile.exists(int'(tpos)))
          push_item(tbpf_pkg::OP_TILE_WR, $urandom, $urandom, tpos[15:0], $urandom);
      end
    end
    push_item(tbpf_pkg::OP_READ, px, py, $urandom, $urandom);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] reg_idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_background(tbpf_pkg::kind_e k, int sx, int sy, int w, int h);
    drain();
    apb_write(tbpf_pkg::REG_KIND, k);
    apb_write(tbpf_pkg::REG_SCROLL_X, sx);
    apb_write(tbpf_pkg::REG_SCROLL_Y, sy);
    apb_write(tbpf_pkg::REG_WIDTH, w);
    apb_write(tbpf_pkg::REG_HEIGHT, h);
    cur_kind = k;
    cur_sx = sx;
    cur_sy = sy;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic random_items(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        if ($urandom_range(1)) push_read($urandom, $urandom);
        else push_read($urandom_range(600) - 300, $urandom_range(600) - 300);
      end else if (r < 75) begin
        push_item(tbpf_pkg::OP_MAP_WR, $urandom, $urandom,
                  $urandom_range(7) == 0 ? $urandom : $urandom_range(MAP_ENTRIES - 1),
                  random_entry());
      end else if (r < 92) begin
        push_item(tbpf_pkg::OP_TILE_WR, $urandom, $urandom, $urandom, $urandom);
      end else begin
        push_item(tbpf_pkg::OP_NOP, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // kind none after reset
    push_read(16'sh7fff, 16'sh8000);
    push_read(0, 0);
    set_background(tbpf_pkg::KIND_TILED, 0, 0, 256, 256);
    push_item(tbpf_pkg::OP_MAP_WR, 16'h7fff, 16'h8000, 16383, 32'hffff_ffff);
    push_item(tbpf_pkg::OP_MAP_WR, 0, 0, 16384, 32'h0);
    push_item(tbpf_pkg::OP_MAP_WR, 16'hffff, 16'hffff, 16'hffff, 32'h5a5a_5a5a);
    push_item(tbpf_pkg::OP_TILE_WR, 0, 0, 16'hffff, 32'hffff_ffff);
    push_item(tbpf_pkg::OP_TILE_WR, 0, 0, 0, 32'h0000_0000);
    push_item(tbpf_pkg::OP_NOP, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    // both flips, then horizontal flip only
    push_item(tbpf_pkg::OP_MAP_WR, 0, 0, 0, 32'h0000_0c05);
    push_item(tbpf_pkg::OP_MAP_WR, 0, 0, 1, 32'hffff_f407);
    push_read(1, 2);
    push_read(9, 3);
    push_read(0, 0);
    push_read(-1, -1);
    push_read(16'sh7fff, 16'sh7fff);
    push_read(16'sh8000, 16'sh8000);
    random_items(30);
    // sender pauses until every result is back
    drain();
    set_background(tbpf_pkg::KIND_TILED, -32768, 32767, 512, 512);
    push_read(300, 20);
    push_read(20, 300);
    push_read(300, 300);
    random_items(80);
    set_background(tbpf_pkg::KIND_TILED, 5, -3, 8192, 8192);
    random_items(30);
    set_background(tbpf_pkg::KIND_TILED, 100, 7, 200, 24);
    random_items(30);
    set_background(tbpf_pkg::KIND_LARGE, 32767, -32768, 8, 8);
    random_items(30);
    set_background(tbpf_pkg::KIND_LARGE, -1, 1, 8192, 16);
    random_items(40);
    set_background(tbpf_pkg::KIND_INF, 12, -40, 64, 8192);
    // a stretch with no idling on either side
    no_idle = 1'b1;
    random_items(40);
    set_background(tbpf_pkg::KIND_INF, 0, 0, 256, 256);
    no_idle = 1'b0;
    random_items(40);
    set_background(tbpf_pkg::KIND_LARGE, 3, 3, 64, 0);
    random_items(10);
    set_background(tbpf_pkg::KIND_TILED, 3, 3, 0, 64);
    random_items(10);
    set_background(tbpf_pkg::KIND_NONE, 0, 0, 256, 256);
    random_items(15);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
